>>> hw/rtl/skt_pkg.sv
// Package for the sorted key table: request and result types, status and
// request codes, and shared constants. No dependencies.
`default_nettype none

package skt_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int KEY_W       = 32;
  localparam int PAYLOAD_W   = 32;
  localparam int POS_W       = 4;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_READ   = 2'd2
  } req_type_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_ENTRY     = 3'd5
  } status_t;

  typedef struct packed {
    req_type_t                    req_type;
    logic signed [KEY_W-1:0]      key;
    logic        [PAYLOAD_W-1:0]  payload;
  } in_t;

  typedef struct packed {
    status_t                      status;
    logic signed [KEY_W-1:0]      out_key;
    logic        [PAYLOAD_W-1:0]  out_payload;
    logic        [POS_W-1:0]      position;
    logic                         last;
  } out_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]      key;
    logic        [PAYLOAD_W-1:0]  payload;
  } entry_t;

  // Result of the shared key comparator: stored key against request key.
  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_t;

  function automatic out_t make_result(status_t st, logic signed [KEY_W-1:0] k,
                                       logic [PAYLOAD_W-1:0] p,
                                       logic [POS_W-1:0] pos, logic lst);
    out_t r;
    r.status      = st;
    r.out_key     = k;
    r.out_payload = p;
    r.position    = pos;
    r.last        = lst;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/skt_cmp.sv
// Shared key comparator of the sorted key table: signed greater-than and
// equality of a stored key against the request key. Uses skt_pkg.
`default_nettype none

module skt_cmp (
  input  wire logic signed [skt_pkg::KEY_W-1:0] entry_key,
  input  wire logic signed [skt_pkg::KEY_W-1:0] req_key,
  output skt_pkg::cmp_t                         result
);
  import skt_pkg::*;

  always_comb begin
    result.gt = entry_key > req_key;
    result.eq = entry_key == req_key;
  end

endmodule

`default_nettype wire

>>> hw/rtl/sorted_key_table.sv
// Sorted key table: a bounded table of (key, payload) records kept in
// ascending signed key order, with insert, delete by key and ordered readout.
// A request is taken when start is high and busy is low; busy stays high
// until the last result of that request has been issued. Results appear one
// per cycle on out_item, marked by out_valid, and cannot be held off by the
// receiver. Records live in a DEPTH-entry memory with one write and one
// registered read port; every step of a request reads that memory, and the
// insert and delete scan steps each use the shared key comparator. An insert
// walks down from the top entry, moving each larger entry up by one; an
// insert into an empty or full table is answered straight from idle. A
// delete scans up from entry 0 and then shifts the tail down. A readout
// issues its results one per cycle, at most 16 results. The memory needs
// no clearing pass after reset. Depends on skt_pkg and skt_cmp.
`default_nettype none

module sorted_key_table #(
  parameter int DEPTH = skt_pkg::DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  skt_pkg::in_t      in_item,
  output logic              busy,
  output logic              out_valid,
  output skt_pkg::out_t     out_item
);
  import skt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_DEL_CMP,
    S_DEL_SH,
    S_RD_OUT
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [AW-1:0]   pos_r, pos_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   last_idx_r, last_idx_nxt;
  in_t             req_r, req_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_t            out_r, out_nxt;

  entry_t          mem [DEPTH];
  entry_t          rdata_r;
  logic            we;
  logic [AW-1:0]   waddr;
  entry_t          wdata;

  cmp_t            cmp;
  entry_t          new_entry;
  logic [CW-1:0]   cnt_m1;
  logic            at_top;

  skt_cmp u_cmp (
    .entry_key (rdata_r.key),
    .req_key   (req_r.key),
    .result    (cmp)
  );

  assign new_entry.key     = req_r.key;
  assign new_entry.payload = req_r.payload;
  assign cnt_m1            = cnt_r - CW'(1);
  assign at_top            = CW'(idx_r) == cnt_m1;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    last_idx_nxt  = last_idx_r;
    req_nxt       = req_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    we            = 1'b0;
    waddr         = idx_r + AW'(1);
    wdata         = rdata_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = in_item;
          case (in_item.req_type)
            REQ_INSERT: begin
              if (cnt_r == CW'(DEPTH)) begin
                out_valid_nxt = 1'b1;
                out_nxt = make_result(ST_FULL, '0, '0, '0, 1'b1);
              end else if (cnt_r == '0) begin
                // Empty table: the record goes straight into entry 0.
                we            = 1'b1;
                waddr         = '0;
                wdata.key     = in_item.key;
                wdata.payload = in_item.payload;
                cnt_nxt       = CW'(1);
                out_valid_nxt = 1'b1;
                out_nxt = make_result(ST_INSERTED, '0, '0, '0, 1'b1);
              end else begin
                idx_nxt   = AW'(cnt_m1);
                state_nxt = S_INS_CMP;
              end
            end
            REQ_DELETE: begin
              if (cnt_r == '0) begin
                out_valid_nxt = 1'b1;
                out_nxt = make_result(ST_EMPTY, '0, '0, '0, 1'b1);
              end else begin
                idx_nxt   = '0;
                state_nxt = S_DEL_CMP;
              end
            end
            REQ_READ: begin
              if (cnt_r == '0) begin
                out_valid_nxt = 1'b1;
                out_nxt = make_result(ST_EMPTY, '0, '0, '0, 1'b1);
              end else begin
                idx_nxt      = '0;
                last_idx_nxt = (32'(cnt_r) > MAX_RESULTS) ? CW'(MAX_RESULTS - 1) : cnt_m1;
                state_nxt    = S_RD_OUT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_INS_CMP: begin
        we = 1'b1;
        if (cmp.gt) begin
          // Larger entry moves up one slot; keep walking down.
          if (idx_r == '0) begin
            state_nxt = S_INS_PUT;
          end else begin
            idx_nxt = idx_r - AW'(1);
          end
        end else begin
          wdata         = new_entry;
          cnt_nxt       = cnt_r + CW'(1);
          out_valid_nxt = 1'b1;
          out_nxt = make_result(ST_INSERTED, '0, '0, POS_W'(idx_r + AW'(1)), 1'b1);
          state_nxt     = S_IDLE;
        end
      end

      S_INS_PUT: begin
        we            = 1'b1;
        waddr         = '0;
        wdata         = new_entry;
        cnt_nxt       = cnt_r + CW'(1);
        out_valid_nxt = 1'b1;
        out_nxt       = make_result(ST_INSERTED, '0, '0, '0, 1'b1);
        state_nxt     = S_IDLE;
      end

      S_DEL_CMP: begin
        if (cmp.eq) begin
          if (at_top) begin
            cnt_nxt       = cnt_m1;
            out_valid_nxt = 1'b1;
            out_nxt = make_result(ST_DELETED, '0, '0, POS_W'(idx_r), 1'b1);
            state_nxt     = S_IDLE;
          end else begin
            pos_nxt   = idx_r;
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_DEL_SH;
          end
        end else if (at_top) begin
          out_valid_nxt = 1'b1;
          out_nxt       = make_result(ST_NOT_FOUND, '0, '0, '0, 1'b1);
          state_nxt     = S_IDLE;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      S_DEL_SH: begin
        we    = 1'b1;
        waddr = idx_r - AW'(1);
        if (at_top) begin
          cnt_nxt       = cnt_m1;
          out_valid_nxt = 1'b1;
          out_nxt = make_result(ST_DELETED, '0, '0, POS_W'(pos_r), 1'b1);
          state_nxt     = S_IDLE;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      S_RD_OUT: begin
        out_valid_nxt = 1'b1;
        out_nxt = make_result(ST_ENTRY, rdata_r.key, rdata_r.payload, POS_W'(idx_r),
                              CW'(idx_r) == last_idx_r);
        if (CW'(idx_r) == last_idx_r) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    last_idx_r <= last_idx_nxt;
    req_r      <= req_nxt;
    out_r      <= out_nxt;
  end

  // Entry memory: the read address follows the next index, so the entry
  // being worked on is in rdata_r during each step.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[idx_nxt];
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count exceeds table depth");

  a_full_reply: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.req_type == REQ_INSERT && cnt_r == CW'(DEPTH)
    |=> out_valid && out_item.status == ST_FULL)
    else $error("insert into full table not reported as full");

  a_readout_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |=> out_valid && out_item.status == ST_ENTRY)
    else $error("readout results not back to back");

  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !busy |-> out_item.last)
    else $error("block idle before the last result of a request");

  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid && out_item.last)
    else $error("request finished without a last result");

endmodule

`default_nettype wire

>>> bench/skt_checker.sv
// Checker for the sorted key table: watches the request and result channels,
// keeps its own copy of the table, and compares each result field by field.
// Depends on skt_pkg for the request and result types and the status codes.
module skt_checker #(
  parameter int DEPTH = skt_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  skt_pkg::in_t  in_item,
  input  logic          out_valid,
  input  skt_pkg::out_t out_item,
  output int            failures,
  output int            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import skt_pkg::*;

  entry_t rec_tbl [DEPTH];
  int     fill = 0;
  out_t   due [$];
  int     fail_cnt = 0;

  assign failures = fail_cnt;

  // Updates the shadow table for one request and queues the results it causes.
  task automatic predict_request(in_t req);
    out_t                    r;
    int                      pos;
    int                      emit;
    logic signed [KEY_W-1:0] k;
    k = req.key;
    r = '0;
    r.last = 1'b1;
    case (req.req_type)
      REQ_INSERT: begin
        if (fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = fill;
          // Equal keys go after the ones already stored.
          for (int i = 0; i < fill; i++) begin
            if (k < rec_tbl[i].key) begin
              pos = i;
              break;
            end
          end
          for (int i = fill; i > pos; i--) rec_tbl[i] = rec_tbl[i-1];
          rec_tbl[pos].key = k;
          rec_tbl[pos].payload = req.payload;
          fill++;
          r.status = ST_INSERTED;
          r.position = pos[POS_W-1:0];
        end
        due.push_back(r);
      end
      REQ_DELETE: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pos = fill;
          for (int i = 0; i < fill; i++) begin
            if (rec_tbl[i].key == k) begin
              pos = i;
              break;
            end
          end
          if (pos == fill) begin
            r.status = ST_NOT_FOUND;
          end else begin
            for (int i = pos; i + 1 < fill; i++) rec_tbl[i] = rec_tbl[i+1];
            fill--;
            r.status = ST_DELETED;
            r.position = pos[POS_W-1:0];
          end
        end
        due.push_back(r);
      end
      REQ_READ: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
          due.push_back(r);
        end else begin
          emit = (fill > MAX_RESULTS) ? MAX_RESULTS : fill;
          for (int i = 0; i < emit; i++) begin
            r.status = ST_ENTRY;
            r.out_key = rec_tbl[i].key;
            r.out_payload = rec_tbl[i].payload;
            r.position = i[POS_W-1:0];
            r.last = (i + 1 == emit);
            due.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(string name, longint exp_v, longint got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_cnt++;
    end
  endtask

  task automatic check_result(out_t got);
    out_t exp_r;
    if (due.size() == 0) begin
      $error("result with status %0d arrived with no request outstanding", got.status);
      fail_cnt++;
    end else begin
      exp_r = due.pop_front();
      compare_field("status", exp_r.status, got.status);
      compare_field("out_key", exp_r.out_key, got.out_key);
      compare_field("out_payload", exp_r.out_payload, got.out_payload);
      compare_field("position", exp_r.position, got.position);
      compare_field("last", exp_r.last, got.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      due.delete();
      fill = 0;
    end else begin
      if (out_valid) check_result(out_item);
      if (start && !busy) predict_request(in_item);
    end
    pending <= due.size();
  end

endmodule

>>> bench/tb.sv
// Top of the sorted key table bench: clock, reset, request stimulus and the
// verdict. Depends on skt_pkg, sorted_key_table and skt_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import skt_pkg::*;

  localparam int RANDOM_REQUESTS = 430;
  localparam int PHASE_LEN       = 40;
  localparam int LIMIT_CYCLES    = 100000;
  localparam int SETTLE_CYCLES   = 40;
  localparam req_type_t REQ_UNUSED = req_type_t'(2'd3);

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  logic  out_valid;
  in_t   in_item;
  out_t  out_item;
  int    failures;
  int    pending;
  int unsigned cycles = 0;
  logic signed [KEY_W-1:0] used_keys [$];

  sorted_key_table uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  skt_checker chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .failures (failures),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic issue(req_type_t op, logic signed [KEY_W-1:0] k,
                       logic [PAYLOAD_W-1:0] p);
    in_t it;
    it.req_type = op;
    it.key = k;
    it.payload = p;
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == REQ_INSERT) begin
      used_keys.push_back(k);
      if (used_keys.size() > 32) void'(used_keys.pop_front());
    end
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Mostly small or repeated keys so that equal keys and hits on delete are common.
  function automatic logic signed [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 35) return $urandom;
    if (r < 60 || used_keys.size() == 0) return int'($urandom_range(6)) - 3;
    if (r < 65) return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
    return used_keys[$urandom_range(used_keys.size() - 1)];
  endfunction

  initial begin
    int  r;
    bit  draining;
    logic signed [KEY_W-1:0] k;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table, ignored selector, ordering with extremes and equal keys.
    issue(REQ_READ, 0, 0);
    issue(REQ_DELETE, 7, 0);
    issue(REQ_UNUSED, -1, '1);
    issue(REQ_INSERT, 5, 32'h0000_0000);
    issue(REQ_INSERT, 32'sh7fffffff, 32'h1234_5678);
    issue(REQ_INSERT, 32'sh80000000, 32'hffff_0000);
    issue(REQ_INSERT, 0, 32'h0000_ffff);
    issue(REQ_INSERT, -1, 32'haaaa_5555);
    issue(REQ_INSERT, 5, 32'hffff_ffff);
    issue(REQ_READ, 0, 0);
    issue(REQ_DELETE, 5, 0);
    issue(REQ_DELETE, 12345, 0);
    issue(REQ_DELETE, 32'sh80000000, 0);
    // Fill the table to its limit, overflow it, then read it all back.
    for (int i = 0; i < 12; i++) issue(REQ_INSERT, i * 3 - 10, $urandom);
    issue(REQ_INSERT, 1, 32'h5555_aaaa);
    issue(REQ_READ, 0, 0);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      // Alternate stretches that drain and fill so both empty and full recur.
      draining = ((n / PHASE_LEN) % 2) == 0;
      r = $urandom_range(99);
      if (r < (draining ? 25 : 60)) begin
        issue(REQ_INSERT, pick_key(), $urandom);
      end else if (r < (draining ? 85 : 82)) begin
        if (used_keys.size() != 0 && $urandom_range(99) < 70)
          k = used_keys[$urandom_range(used_keys.size() - 1)];
        else
          k = pick_key();
        issue(REQ_DELETE, k, $urandom);
      end else begin
        issue(REQ_READ, $urandom, $urandom);
      end
      if ($urandom_range(99) < 3) issue(REQ_UNUSED, $urandom, $urandom);
      if ((n < 150 || n >= 300) && $urandom_range(99) < 8)
        pause($urandom_range(1, 6));
    end

    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/skt_pkg.sv
hw/rtl/skt_cmp.sv
hw/rtl/sorted_key_table.sv
bench/skt_checker.sv
bench/tb.sv
